FILE: hw/rtl/crank_angle_event_scheduler_defines.svh
// assertion macros for the crank angle event scheduler
// included by modules that carry concurrent checks, no other dependencies
`ifndef CRANK_ANGLE_EVENT_SCHEDULER_DEFINES_SVH
`define CRANK_ANGLE_EVENT_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define CAE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CAE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/cae_pkg.sv
// shared types and constants of the crank angle event scheduler
// no dependencies
package cae_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int CYCLE_DEGREES_DEF = 720;

	localparam logic [2:0] CMD_UPDATE = 3'd0;
	localparam logic [2:0] CMD_ADD    = 3'd1;
	localparam logic [2:0] CMD_TICK   = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_REMOVE = 3'd4;

	localparam int DIV_BITS = 26;
	localparam logic [DIV_BITS-1:0] US_PER_MINUTE = 26'd60000000;
	localparam logic [15:0] MIN_RPM = 16'd100;
	localparam logic [31:0] LATE_LIMIT_US = 32'd1000;
	localparam logic [8:0] DEG_PER_REV = 9'd360;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] angle;
		logic [15:0] rpm;
		logic [31:0] time_us;
		logic [7:0]  cylinder;
	} in_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  fired_cylinder;
		logic        late;
		logic        accepted;
		logic [5:0]  active_count;
		logic [31:0] scheduled_total;
		logic [31:0] fired_total;
		logic [31:0] missed_total;
		logic [9:0]  angle_now;
		logic [31:0] time_per_degree;
		logic        last;
	} out_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [9:0]  angle;
		logic [31:0] upd;
		logic [31:0] now;
		logic [7:0]  cyl;
	} job_t;

endpackage

FILE: hw/rtl/cae_ram.sv
// generic single write port ram with registered read
// no dependencies
module cae_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

FILE: hw/rtl/cae_front.sv
// front end: accepts transactions, reduces the angle, derives time per degree
// depends on cae_pkg
module cae_front #(
	parameter int CYCLE_DEGREES = cae_pkg::CYCLE_DEGREES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  cae_pkg::in_t  item,
	output logic          job_valid,
	input  logic          job_ready,
	output cae_pkg::job_t job
);
	localparam int MOD_STEPS = $clog2((65536 + CYCLE_DEGREES - 1) / CYCLE_DEGREES);
	localparam int DB = cae_pkg::DIV_BITS;
	localparam logic [31:0] MOD_BASE = 32'(CYCLE_DEGREES);

	typedef enum logic [1:0] {F_IDLE, F_WORK, F_PUSH} fstate_t;

	fstate_t         state_q;
	logic [2:0]      cmd_q;
	logic [15:0]     ang_q;
	logic            slow_q;
	logic [24:0]     dvs_q;
	logic [DB-1:0]   rem_q;
	logic [DB-1:0]   quo_q;
	logic [4:0]      cnt_q;
	logic [31:0]     now_q;
	logic [7:0]      cyl_q;

	logic [DB-1:0]   rem_sh;
	logic            qbit;
	logic [4:0]      bit_idx;
	logic [4:0]      k;
	logic [31:0]     mod_sub;

	always_comb begin
		bit_idx = 5'(DB - 1) - cnt_q;
		rem_sh  = {rem_q[DB-2:0], cae_pkg::US_PER_MINUTE[bit_idx]};
		qbit    = rem_sh >= {1'b0, dvs_q};
		k       = 5'(MOD_STEPS - 1) - cnt_q;
		mod_sub = MOD_BASE << k;
	end

	assign item_ready = (state_q == F_IDLE);
	assign job_valid  = (state_q == F_PUSH);
	assign job.cmd    = cmd_q;
	assign job.angle  = ang_q[9:0];
	assign job.upd    = slow_q ? '1 : 32'(quo_q);
	assign job.now    = now_q;
	assign job.cyl    = cyl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (item_valid) begin
						cmd_q   <= item.cmd;
						ang_q   <= item.angle;
						slow_q  <= item.rpm < cae_pkg::MIN_RPM;
						dvs_q   <= 25'(item.rpm) * 25'(cae_pkg::DEG_PER_REV);
						now_q   <= item.time_us;
						cyl_q   <= item.cylinder;
						rem_q   <= '0;
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= F_WORK;
					end
				end
				F_WORK: begin
					rem_q <= qbit ? rem_sh - {1'b0, dvs_q} : rem_sh;
					quo_q <= {quo_q[DB-2:0], qbit};
					if (cnt_q < 5'(MOD_STEPS) && {16'd0, ang_q} >= mod_sub) begin
						ang_q <= ang_q - 16'(mod_sub);
					end
					if (cnt_q == 5'(DB - 1)) begin
						state_q <= F_PUSH;
					end
					cnt_q <= cnt_q + 5'd1;
				end
				F_PUSH: begin
					if (job_ready) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

FILE: hw/rtl/cae_queue.sv
// two-entry queue between front and back
// depends on cae_pkg
module cae_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  cae_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output cae_pkg::job_t pop_data
);
	cae_pkg::job_t mem_q [2];
	logic          wptr_q;
	logic          rptr_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (do_pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

FILE: hw/rtl/cae_back.sv
// back end: walks the slot table for each job and emits result transactions
// depends on cae_pkg, cae_ram and the assertion macro header
`include "crank_angle_event_scheduler_defines.svh"

module cae_back #(
	parameter int SLOTS         = cae_pkg::SLOTS_DEF,
	parameter int CYCLE_DEGREES = cae_pkg::CYCLE_DEGREES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  cae_pkg::job_t pop_data,
	output logic          res_valid,
	input  logic          res_ready,
	output cae_pkg::out_t res
);
	localparam int IW = SLOTS > 1 ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int SW = 10 + 8 + 32;

	typedef enum logic [2:0] {B_IDLE, B_WALK, B_RD, B_LD, B_WAIT, B_STAT, B_SWAIT} bstate_t;

	typedef struct packed {
		logic [9:0]  angle;
		logic [7:0]  cyl;
		logic [31:0] due;
	} slot_t;

	bstate_t        state_q;
	cae_pkg::job_t  job_q;
	logic [9:0]     cur_q;
	logic [31:0]    upd_q;
	logic [SLOTS-1:0] active_q;
	logic [5:0]     act_cnt_q;
	logic [31:0]    added_q;
	logic [31:0]    fired_q;
	logic [31:0]    late_q;
	logic [CW-1:0]  cnt_q;
	logic           pv_s1;
	logic [IW-1:0]  idx_s1;
	logic           found_q;
	logic           acc_q;
	logic [CW-1:0]  nf_q;
	logic [CW-1:0]  ptr_q;
	cae_pkg::out_t  res_q;
	logic           res_valid_q;

	slot_t          rd_slot;
	logic [SW-1:0]  rd_raw;
	slot_t          wr_slot;
	logic           slot_we;
	logic [8:0]     fire_rd;
	logic           fire_we;
	logic           act;
	logic [9:0]     tgt;
	logic [10:0]    delta;
	logic [31:0]    prod;
	logic           due_hit;
	logic           is_late;
	logic           do_add;
	logic           do_fire;
	logic           do_drop;

	assign rd_slot = slot_t'(rd_raw);

	always_comb begin
		act     = active_q[idx_s1];
		tgt     = (job_q.cmd == cae_pkg::CMD_ADD) ? job_q.angle : rd_slot.angle;
		delta   = (tgt >= cur_q) ? {1'b0, tgt} - {1'b0, cur_q}
		                         : {1'b0, tgt} + 11'(CYCLE_DEGREES) - {1'b0, cur_q};
		prod    = 32'({21'd0, delta} * upd_q);
		due_hit = job_q.now >= rd_slot.due;
		is_late = (job_q.now - rd_slot.due) > cae_pkg::LATE_LIMIT_US;
		do_add  = 1'b0;
		do_fire = 1'b0;
		do_drop = 1'b0;
		slot_we = 1'b0;
		wr_slot = rd_slot;
		wr_slot.due = job_q.now + prod;
		if (pv_s1) begin
			case (job_q.cmd)
				cae_pkg::CMD_UPDATE: slot_we = act;
				cae_pkg::CMD_ADD: begin
					do_add  = !act && !found_q;
					slot_we = do_add;
					wr_slot.angle = job_q.angle;
					wr_slot.cyl   = job_q.cyl;
				end
				cae_pkg::CMD_TICK:   do_fire = act && due_hit;
				cae_pkg::CMD_CLEAR:  do_drop = act;
				cae_pkg::CMD_REMOVE: do_drop = act && rd_slot.cyl == job_q.cyl;
				default: ;
			endcase
		end
		fire_we = do_fire;
	end

	cae_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (idx_s1),
		.wdata (SW'(wr_slot)),
		.raddr (cnt_q[IW-1:0]),
		.rdata (rd_raw)
	);

	cae_ram #(.WIDTH(9), .DEPTH(SLOTS)) u_fire_ram (
		.clk   (clk),
		.we    (fire_we),
		.waddr (nf_q[IW-1:0]),
		.wdata ({rd_slot.cyl, is_late}),
		.raddr (ptr_q[IW-1:0]),
		.rdata (fire_rd)
	);

	assign pop_ready = (state_q == B_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			cur_q       <= '0;
			upd_q       <= '0;
			active_q    <= '0;
			act_cnt_q   <= '0;
			added_q     <= '0;
			fired_q     <= '0;
			late_q      <= '0;
			cnt_q       <= '0;
			pv_s1       <= 1'b0;
			idx_s1      <= '0;
			found_q     <= 1'b0;
			acc_q       <= 1'b0;
			nf_q        <= '0;
			ptr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						job_q <= pop_data;
						if (pop_data.cmd == cae_pkg::CMD_UPDATE) begin
							cur_q <= pop_data.angle;
							upd_q <= pop_data.upd;
						end
						cnt_q   <= '0;
						pv_s1   <= 1'b0;
						found_q <= 1'b0;
						acc_q   <= 1'b0;
						nf_q    <= '0;
						ptr_q   <= '0;
						state_q <= B_WALK;
					end
				end
				B_WALK: begin
					if (cnt_q < CW'(SLOTS)) begin
						pv_s1  <= 1'b1;
						idx_s1 <= cnt_q[IW-1:0];
						cnt_q  <= cnt_q + CW'(1);
					end else begin
						pv_s1 <= 1'b0;
						if (!pv_s1) begin
							state_q <= (nf_q != '0) ? B_RD : B_STAT;
						end
					end
					if (do_add) begin
						active_q[idx_s1] <= 1'b1;
						act_cnt_q        <= act_cnt_q + 6'd1;
						added_q          <= added_q + 32'd1;
						found_q          <= 1'b1;
						acc_q            <= 1'b1;
					end
					if (do_fire || do_drop) begin
						active_q[idx_s1] <= 1'b0;
						act_cnt_q        <= act_cnt_q - 6'd1;
					end
					if (do_fire) begin
						fired_q <= fired_q + 32'd1;
						nf_q    <= nf_q + CW'(1);
						if (is_late) begin
							late_q <= late_q + 32'd1;
						end
					end
				end
				B_RD: state_q <= B_LD;
				B_LD: begin
					res_q.kind            <= 1'b0;
					res_q.fired_cylinder  <= fire_rd[8:1];
					res_q.late            <= fire_rd[0];
					res_q.accepted        <= 1'b0;
					res_q.active_count    <= act_cnt_q;
					res_q.scheduled_total <= added_q;
					res_q.fired_total     <= fired_q;
					res_q.missed_total    <= late_q;
					res_q.angle_now       <= cur_q;
					res_q.time_per_degree <= upd_q;
					res_q.last            <= 1'b0;
					res_valid_q           <= 1'b1;
					ptr_q                 <= ptr_q + CW'(1);
					state_q               <= B_WAIT;
				end
				B_WAIT: begin
					if (res_ready) begin
						res_valid_q <= 1'b0;
						state_q     <= (ptr_q == nf_q) ? B_STAT : B_RD;
					end
				end
				B_STAT: begin
					res_q.kind            <= 1'b1;
					res_q.fired_cylinder  <= '0;
					res_q.late            <= 1'b0;
					res_q.accepted        <= acc_q;
					res_q.active_count    <= act_cnt_q;
					res_q.scheduled_total <= added_q;
					res_q.fired_total     <= fired_q;
					res_q.missed_total    <= late_q;
					res_q.angle_now       <= cur_q;
					res_q.time_per_degree <= upd_q;
					res_q.last            <= 1'b1;
					res_valid_q           <= 1'b1;
					state_q               <= B_SWAIT;
				end
				B_SWAIT: begin
					if (res_ready) begin
						res_valid_q <= 1'b0;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	`CAE_ASSERT_IMP(a_count_match, clk, arst_n, 1'b1, $countones(active_q) == int'(act_cnt_q), "active count out of step with active slots")
	`CAE_ASSERT_IMP(a_last_is_status, clk, arst_n, res_valid_q, res_q.last == res_q.kind, "last flag not on status transaction")
	`CAE_ASSERT_NXT(a_single_add, clk, arst_n, do_add, !do_add, "two slots taken by one add")
	`CAE_ASSERT_IMP(a_fire_bound, clk, arst_n, state_q == B_WAIT, ptr_q <= nf_q, "emitted more fired transactions than recorded")
endmodule

FILE: hw/rtl/crank_angle_event_scheduler.sv
// crank angle event scheduler: the front end runs a 26-step restoring divider for time
// per degree, and the back end walks the slot table for each transaction and then emits
// one result transaction per fired event and a status transaction
// front and back overlap through a two-entry queue
// asynchronous active-low reset clears all slots, counters, angle and time per degree
// depends on cae_pkg, cae_front, cae_queue, cae_back
module crank_angle_event_scheduler #(
	parameter int SLOTS         = cae_pkg::SLOTS_DEF,
	parameter int CYCLE_DEGREES = cae_pkg::CYCLE_DEGREES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	output logic          item_ready,
	input  cae_pkg::in_t  item,
	output logic          res_valid,
	input  logic          res_ready,
	output cae_pkg::out_t res
);
	logic          f_valid;
	logic          f_ready;
	cae_pkg::job_t f_job;
	logic          b_valid;
	logic          b_ready;
	cae_pkg::job_t b_job;

	cae_front #(.CYCLE_DEGREES(CYCLE_DEGREES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.job_valid  (f_valid),
		.job_ready  (f_ready),
		.job        (f_job)
	);

	cae_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (f_job),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (b_job)
	);

	cae_back #(.SLOTS(SLOTS), .CYCLE_DEGREES(CYCLE_DEGREES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_job),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);
endmodule

FILE: tb/tb.sv
// self-checking testbench for crank_angle_event_scheduler
// predicts every result transaction of each accepted command and compares each whole transaction
// depends on cae_pkg and the scheduler rtl
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSLOT = cae_pkg::SLOTS_DEF;
	localparam int NDEG = cae_pkg::CYCLE_DEGREES_DEF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	cae_pkg::in_t item = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	cae_pkg::out_t res;

	always #4 clk = ~clk;

	crank_angle_event_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	// scheduler shadow state
	logic        sh_active [NSLOT];
	logic [9:0]  sh_angle [NSLOT];
	logic [7:0]  sh_cyl [NSLOT];
	logic [31:0] sh_due [NSLOT];
	logic [9:0]  sh_now_angle = '0;
	logic [31:0] sh_upd = '0;
	logic [5:0]  sh_count = '0;
	logic [31:0] sh_added = '0, sh_fired = '0, sh_late = '0;

	cae_pkg::in_t  pending_cmds [$];
	cae_pkg::out_t expected_res [$];
	int   errors = 0;
	int   send_idle = 0, recv_stall = 0;
	bit   hold_off = 0;

	function automatic logic [31:0] delay_to(input logic [9:0] tgt);
		logic [31:0] d;
		if (tgt >= sh_now_angle) d = 32'(tgt) - 32'(sh_now_angle);
		else d = 32'(tgt) + 32'(NDEG) - 32'(sh_now_angle);
		return d * sh_upd;
	endfunction

	function automatic void predict_cmd(input cae_pkg::in_t c);
		cae_pkg::out_t outs [$];
		cae_pkg::out_t o;
		logic [9:0] ang;
		logic acc;
		logic lt;
		ang = 10'(c.angle % NDEG);
		acc = 1'b0;
		case (c.cmd)
			cae_pkg::CMD_UPDATE: begin
				sh_now_angle = ang;
				if (c.rpm >= cae_pkg::MIN_RPM) sh_upd = 32'd60000000 / (32'(c.rpm) * 32'd360);
				else sh_upd = 32'hFFFFFFFF;
				for (int i = 0; i < NSLOT; i++)
					if (sh_active[i]) sh_due[i] = c.time_us + delay_to(sh_angle[i]);
			end
			cae_pkg::CMD_ADD: begin
				for (int i = 0; i < NSLOT; i++)
					if (!sh_active[i]) begin
						sh_angle[i] = ang;
						sh_cyl[i] = c.cylinder;
						sh_active[i] = 1'b1;
						sh_due[i] = c.time_us + delay_to(ang);
						sh_count++;
						sh_added++;
						acc = 1'b1;
						break;
					end
			end
			cae_pkg::CMD_TICK: begin
				for (int i = 0; i < NSLOT; i++)
					if (sh_active[i] && c.time_us >= sh_due[i]) begin
						lt = (c.time_us - sh_due[i]) > cae_pkg::LATE_LIMIT_US;
						sh_active[i] = 1'b0;
						sh_count--;
						sh_fired++;
						if (lt) sh_late++;
						o = '0;
						o.fired_cylinder = sh_cyl[i];
						o.late = lt;
						outs.push_back(o);
					end
			end
			cae_pkg::CMD_CLEAR: begin
				for (int i = 0; i < NSLOT; i++) sh_active[i] = 1'b0;
				sh_count = '0;
			end
			cae_pkg::CMD_REMOVE: begin
				for (int i = 0; i < NSLOT; i++)
					if (sh_active[i] && sh_cyl[i] == c.cylinder) begin
						sh_active[i] = 1'b0;
						sh_count--;
					end
			end
			default: ;
		endcase
		o = '0;
		o.kind = 1'b1;
		o.accepted = acc;
		o.last = 1'b1;
		outs.push_back(o);
		foreach (outs[k]) begin
			outs[k].active_count = sh_count;
			outs[k].scheduled_total = sh_added;
			outs[k].fired_total = sh_fired;
			outs[k].missed_total = sh_late;
			outs[k].angle_now = sh_now_angle;
			outs[k].time_per_degree = sh_upd;
			expected_res.push_back(outs[k]);
		end
	endfunction

	// driver
	always @(posedge clk) begin
		if (item_valid && item_ready) predict_cmd(item);
		if (!item_valid || item_ready) begin
			if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
				item_valid <= 1'b1;
				item <= pending_cmds.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (res_valid && res_ready) begin
			if (expected_res.size() == 0) begin
				$display("%0t unexpected result %p", $time, res);
				errors++;
			end else begin
				cae_pkg::out_t e;
				e = expected_res.pop_front();
				if (res !== e) begin
					$display("%0t mismatch: expected %p actual %p", $time, e, res);
					errors++;
				end
			end
		end
		res_ready <= !hold_off && ($urandom_range(99) >= recv_stall);
	end

	function automatic cae_pkg::in_t mk(input logic [2:0] c, input logic [15:0] a,
		input logic [15:0] r, input logic [31:0] t, input logic [7:0] cy);
		cae_pkg::in_t x;
		x.cmd = c; x.angle = a; x.rpm = r; x.time_us = t; x.cylinder = cy;
		return x;
	endfunction

	function automatic cae_pkg::in_t rand_cmd(input logic [31:0] base);
		cae_pkg::in_t x;
		int p;
		x = cae_pkg::in_t'($bits(cae_pkg::in_t)'({$urandom, $urandom, $urandom}));
		p = $urandom_range(99);
		if (p < 25) x.cmd = cae_pkg::CMD_ADD;
		else if (p < 50) x.cmd = cae_pkg::CMD_TICK;
		else if (p < 70) x.cmd = cae_pkg::CMD_UPDATE;
		else if (p < 80) x.cmd = cae_pkg::CMD_REMOVE;
		else if (p < 85) x.cmd = cae_pkg::CMD_CLEAR;
		else if (p < 88) x.cmd = 3'($urandom_range(5, 7));
		if (p < 80) begin
			if ($urandom_range(3) != 0) x.rpm = 16'($urandom_range(100, 8000));
			if ($urandom_range(3) != 0) x.angle = 16'($urandom_range(0, 719));
			if ($urandom_range(3) != 0) x.time_us = base + $urandom_range(0, 400000);
			if ($urandom_range(3) != 0) x.cylinder = 8'($urandom_range(0, 7));
		end
		return x;
	endfunction

	task automatic drain();
		while (pending_cmds.size() > 0 || item_valid || expected_res.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	initial begin
		logic [31:0] base;
		for (int i = 0; i < NSLOT; i++) sh_active[i] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		pending_cmds.push_back(mk(cae_pkg::CMD_UPDATE, 16'd0, 16'd0, 32'd0, 8'd0));
		pending_cmds.push_back(mk(cae_pkg::CMD_UPDATE, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 8'hFF));
		pending_cmds.push_back(mk(cae_pkg::CMD_UPDATE, 16'd10, 16'd100, 32'd0, 8'd0));
		pending_cmds.push_back(mk(cae_pkg::CMD_UPDATE, 16'd10, 16'd99, 32'd0, 8'd0));
		pending_cmds.push_back(mk(cae_pkg::CMD_UPDATE, 16'd700, 16'd6000, 32'd1000, 8'd0));
		for (int i = 0; i < 17; i++)
			pending_cmds.push_back(mk(cae_pkg::CMD_ADD, 16'(i * 45), 16'd0, 32'd1000,
				8'(i == 16 ? 255 : i % 4)));
		pending_cmds.push_back(mk(cae_pkg::CMD_REMOVE, 16'd0, 16'd0, 32'd0, 8'd3));
		pending_cmds.push_back(mk(cae_pkg::CMD_TICK, 16'd0, 16'd0, 32'd3000, 8'd0));
		pending_cmds.push_back(mk(cae_pkg::CMD_TICK, 16'd0, 16'd0, 32'hFFFFFFFF, 8'd0));
		pending_cmds.push_back(mk(3'd7, 16'd0, 16'd0, 32'd0, 8'd0));
		pending_cmds.push_back(mk(cae_pkg::CMD_CLEAR, 16'd0, 16'd0, 32'd0, 8'd0));
		drain();

		// random phases
		base = 0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? 73 : 0;
			recv_stall = (ph == 2) ? 73 : (ph == 3 ? 14 : 0);
			if (ph == 3) send_idle = 14;
			for (int n = 0; n < 96; n++) begin
				pending_cmds.push_back(rand_cmd(base));
				if ($urandom_range(7) == 0) base += $urandom_range(0, 300000);
			end
			if (ph == 0) begin
				hold_off = 1;
				repeat (600) @(posedge clk);
				hold_off = 0;
			end
			drain();
		end

		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule
